// ----- design/etf_pkg.sv -----
// Shared constants and types for the escape-time fractal pixel block.
// Used by the multiplier cells, the gray-level divider and the top level.
package etf_pkg;

   // Fixed-point format of plane values (Q4.28).
   localparam int FRAC_BITS  = 28;
   localparam int OP_BITS    = 32;
   localparam int ACC_BITS   = 2 * OP_BITS;
   localparam int Z_BITS     = 40;

   // Multiplier chain: each cell consumes one slice of the second operand.
   localparam int SLICE_BITS = 8;
   localparam int NUM_CELLS  = OP_BITS / SLICE_BITS;
   localparam int PART_BITS  = OP_BITS + SLICE_BITS;

   // Iteration count and gray level.
   localparam int LIMIT_BITS    = 10;
   localparam int GRAY_BITS     = 8;
   localparam int DIVIDEND_BITS = LIMIT_BITS + GRAY_BITS;
   localparam int STEP_BITS     = $clog2(GRAY_BITS);

   // Stream payload widths.
   localparam int REQ_DATA_BITS = 2 * OP_BITS;
   localparam int RSP_DATA_BITS = 24;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - LIMIT_BITS - GRAY_BITS;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRACTAL_MODE    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_JULIA_CONST_RE  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_JULIA_CONST_IM  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ITERATION_LIMIT = 3'd3;

   localparam logic signed [OP_BITS-1:0] JULIA_RE_RESET = 32'sd107374182;
   localparam logic signed [OP_BITS-1:0] JULIA_IM_RESET = 32'sd80530637;
   localparam logic [LIMIT_BITS-1:0]     LIMIT_RESET    = 10'd100;

   // Escape thresholds: |z|^2 > 4 in the squared scale, and |part| > 2.
   localparam logic [ACC_BITS-1:0] ESC_SUM = 64'd1 << (2 * FRAC_BITS + 2);
   localparam logic signed [Z_BITS-1:0] Z_BOUND = Z_BITS'(64'd1 << (FRAC_BITS + 1));

   // Data handed from one multiplier cell to the next.
   typedef struct packed {
      logic [OP_BITS-1:0]  mag_re;
      logic [OP_BITS-1:0]  mag_im;
      logic [OP_BITS-1:0]  b_re;
      logic [OP_BITS-1:0]  b_im;
      logic [ACC_BITS-1:0] acc_rr;
      logic [ACC_BITS-1:0] acc_ii;
      logic [ACC_BITS-1:0] acc_ri;
   } etf_cell_data_type;

endpackage

// ----- design/etf_cell.sv -----
// One cell of the squaring chain: folds one slice of the operands into
// the three running products. Depends on etf_pkg.
module etf_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       prev_valid,
   input  etf_pkg::etf_cell_data_type prev_data,
   output logic                       next_valid,
   output etf_pkg::etf_cell_data_type next_data
);
   import etf_pkg::*;

   logic [SLICE_BITS-1:0] slice_re;
   logic [SLICE_BITS-1:0] slice_im;
   logic [PART_BITS-1:0]  part_rr;
   logic [PART_BITS-1:0]  part_ii;
   logic [PART_BITS-1:0]  part_ri;
   etf_cell_data_type     data_in;
   etf_cell_data_type     data_ff;
   logic                  valid_ff;

   // Slices go most significant first, so the running sum shifts up a slice.
   assign slice_re = prev_data.b_re[OP_BITS-1 -: SLICE_BITS];
   assign slice_im = prev_data.b_im[OP_BITS-1 -: SLICE_BITS];
   assign part_rr  = PART_BITS'(prev_data.mag_re) * PART_BITS'(slice_re);
   assign part_ii  = PART_BITS'(prev_data.mag_im) * PART_BITS'(slice_im);
   assign part_ri  = PART_BITS'(prev_data.mag_re) * PART_BITS'(slice_im);

   always_comb begin
      data_in        = prev_data;
      data_in.b_re   = {prev_data.b_re[OP_BITS-SLICE_BITS-1:0], SLICE_BITS'(0)};
      data_in.b_im   = {prev_data.b_im[OP_BITS-SLICE_BITS-1:0], SLICE_BITS'(0)};
      data_in.acc_rr = {prev_data.acc_rr[ACC_BITS-SLICE_BITS-1:0], SLICE_BITS'(0)}
                       + ACC_BITS'(part_rr);
      data_in.acc_ii = {prev_data.acc_ii[ACC_BITS-SLICE_BITS-1:0], SLICE_BITS'(0)}
                       + ACC_BITS'(part_ii);
      data_in.acc_ri = {prev_data.acc_ri[ACC_BITS-SLICE_BITS-1:0], SLICE_BITS'(0)}
                       + ACC_BITS'(part_ri);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign next_valid = valid_ff;
   assign next_data  = data_ff;

endmodule

// ----- design/etf_divider.sv -----
// Restoring divider for the gray level, one quotient bit per cycle.
// Depends on etf_pkg.
module etf_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [etf_pkg::DIVIDEND_BITS-1:0]   dividend,
   input  logic [etf_pkg::LIMIT_BITS-1:0]      divisor,
   output logic                                done,
   output logic [etf_pkg::GRAY_BITS-1:0]       quotient
);
   import etf_pkg::*;

   logic [DIVIDEND_BITS-1:0] rem_ff;
   logic [DIVIDEND_BITS-1:0] rem_in;
   logic [DIVIDEND_BITS-1:0] dsh_ff;
   logic [DIVIDEND_BITS-1:0] dsh_in;
   logic [GRAY_BITS-1:0]     quo_ff;
   logic [GRAY_BITS-1:0]     quo_in;
   logic [STEP_BITS-1:0]     step_ff;
   logic [STEP_BITS-1:0]     step_in;
   logic                     busy_ff;
   logic                     busy_in;
   logic                     done_ff;
   logic                     done_in;
   logic                     fits;

   // The quotient is known to stay below 2^GRAY_BITS, so the divisor
   // starts shifted up by GRAY_BITS-1 places.
   assign fits = (rem_ff >= dsh_ff);

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         dsh_in  = DIVIDEND_BITS'(divisor) << (GRAY_BITS - 1);
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? (rem_ff - dsh_ff) : rem_ff;
         dsh_in  = dsh_ff >> 1;
         quo_in  = {quo_ff[GRAY_BITS-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(GRAY_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- design/escape_time_fractal_pixel_top.sv -----
// Escape-time fractal pixel: Mandelbrot or Julia iteration count and gray level per point.
// Each iteration done passes launch, four chain cells and update; after the last chain pass
// come the gray division and the load of the output register.
// Throughput: one point at a time; the iteration loop through the cell chain sets the rate.
// Reset is synchronous: control state clears and the registers return to their defaults.
module escape_time_fractal_pixel_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // Point beats. tdata fields from bit 0: point_re[31:0], point_im[31:0].
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [etf_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // Result beats. tdata fields from bit 0: remaining_count[9:0], gray_level[7:0],
   // then zero padding.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [etf_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // Register writes.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [etf_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [etf_pkg::OP_BITS-1:0]          csr_data
);
   import etf_pkg::*;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LAUNCH = 3'd1;
   localparam logic [2:0] ST_RUN    = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_DIVIDE = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   // Configuration registers.
   logic                         mode_ff;
   logic signed [OP_BITS-1:0]    jre_ff;
   logic signed [OP_BITS-1:0]    jim_ff;
   logic [LIMIT_BITS-1:0]        limit_ff;

   // Iteration state.
   logic [2:0]                   state_ff, state_in;
   logic signed [OP_BITS-1:0]    z_re_ff, z_re_in;
   logic signed [OP_BITS-1:0]    z_im_ff, z_im_in;
   logic signed [OP_BITS-1:0]    c_re_ff, c_re_in;
   logic signed [OP_BITS-1:0]    c_im_ff, c_im_in;
   logic [LIMIT_BITS-1:0]        k_ff, k_in;
   logic signed [Z_BITS-1:0]     nre_ff, nre_in;
   logic signed [Z_BITS-1:0]     nim_ff, nim_in;
   logic [LIMIT_BITS-1:0]        count_ff, count_in;

   // Output register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [LIMIT_BITS-1:0]        rsp_count_ff, rsp_count_in;
   logic [GRAY_BITS-1:0]         rsp_gray_ff, rsp_gray_in;

   // Squaring chain.
   logic [OP_BITS-1:0]           mag_re;
   logic [OP_BITS-1:0]           mag_im;
   logic [NUM_CELLS:0]           chain_valid;
   etf_cell_data_type            chain_data [NUM_CELLS+1];
   etf_cell_data_type            tail;

   // Update arithmetic.
   logic [ACC_BITS-1:0]          sum_sq;
   logic                         fine_escape;
   logic signed [ACC_BITS-1:0]   prod_ri;
   logic [ACC_BITS-1:0]          sq_re_sh;
   logic [ACC_BITS-1:0]          sq_im_sh;
   logic signed [ACC_BITS-1:0]   cross_sh;
   logic signed [Z_BITS-1:0]     new_re;
   logic signed [Z_BITS-1:0]     new_im;
   logic                         coarse_escape;
   logic [LIMIT_BITS-1:0]        k_next;

   // Gray-level division.
   logic                         div_start;
   logic                         div_done;
   logic [DIVIDEND_BITS-1:0]     div_dividend;
   logic [GRAY_BITS-1:0]         div_quotient;

   logic                         req_beat;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Register writes; an index past the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         jre_ff   <= JULIA_RE_RESET;
         jim_ff   <= JULIA_IM_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FRACTAL_MODE:    mode_ff  <= csr_data[0];
            CSR_JULIA_CONST_RE:  jre_ff   <= csr_data;
            CSR_JULIA_CONST_IM:  jim_ff   <= csr_data;
            CSR_ITERATION_LIMIT: limit_ff <= csr_data[LIMIT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // The chain multiplies magnitudes; the sign of the cross product is put back
   // afterwards, and z stays put while a pass is in flight. Every z that enters
   // the chain is either the starting point or a point inside |part| <= 2, so it
   // always fits the 32-bit operand.
   assign mag_re = z_re_ff[OP_BITS-1] ? (~z_re_ff + 1'b1) : z_re_ff;
   assign mag_im = z_im_ff[OP_BITS-1] ? (~z_im_ff + 1'b1) : z_im_ff;

   assign chain_valid[0] = (state_ff == ST_LAUNCH);
   assign chain_data[0]  = '{mag_re: mag_re, mag_im: mag_im, b_re: mag_re, b_im: mag_im,
                             acc_rr: '0, acc_ii: '0, acc_ri: '0};

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      etf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .prev_valid (chain_valid[i]),
         .prev_data  (chain_data[i]),
         .next_valid (chain_valid[i+1]),
         .next_data  (chain_data[i+1])
      );
   end

   assign tail = chain_data[NUM_CELLS];

   // The squares coming out of the chain serve twice: as the exact escape test
   // of the current z and as the terms of the next z. The starting z is never
   // tested, hence the check on the iteration count.
   assign sum_sq      = tail.acc_rr + tail.acc_ii;
   assign fine_escape = (k_ff != '0) && (sum_sq > ESC_SUM);
   assign prod_ri     = (z_re_ff[OP_BITS-1] ^ z_im_ff[OP_BITS-1]) ?
                        (~tail.acc_ri + 1'b1) : tail.acc_ri;
   assign sq_re_sh    = tail.acc_rr >> FRAC_BITS;
   assign sq_im_sh    = tail.acc_ii >> FRAC_BITS;
   assign cross_sh    = prod_ri >>> (FRAC_BITS - 1);
   assign new_re      = Z_BITS'(sq_re_sh) - Z_BITS'(sq_im_sh)
                        + {{(Z_BITS-OP_BITS){c_re_ff[OP_BITS-1]}}, c_re_ff};
   assign new_im      = Z_BITS'(cross_sh)
                        + {{(Z_BITS-OP_BITS){c_im_ff[OP_BITS-1]}}, c_im_ff};

   // A part beyond 2 in magnitude means escape without squaring; otherwise the
   // new z fits the operand width and goes around the chain again.
   assign coarse_escape = (nre_ff > Z_BOUND) || (nre_ff < -Z_BOUND) ||
                          (nim_ff > Z_BOUND) || (nim_ff < -Z_BOUND);
   assign k_next        = k_ff + 1'b1;

   // 255 * count as a shift and subtract.
   assign div_dividend = (DIVIDEND_BITS'(count_in) << GRAY_BITS) - DIVIDEND_BITS'(count_in);

   etf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (limit_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in     = state_ff;
      z_re_in      = z_re_ff;
      z_im_in      = z_im_ff;
      c_re_in      = c_re_ff;
      c_im_in      = c_im_ff;
      k_in         = k_ff;
      nre_in       = nre_ff;
      nim_in       = nim_ff;
      count_in     = count_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_count_in = rsp_count_ff;
      rsp_gray_in  = rsp_gray_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               if (mode_ff) begin
                  z_re_in = req_tdata[OP_BITS-1:0];
                  z_im_in = req_tdata[2*OP_BITS-1:OP_BITS];
                  c_re_in = jre_ff;
                  c_im_in = jim_ff;
               end else begin
                  z_re_in = '0;
                  z_im_in = '0;
                  c_re_in = req_tdata[OP_BITS-1:0];
                  c_im_in = req_tdata[2*OP_BITS-1:OP_BITS];
               end
               k_in     = '0;
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (chain_valid[NUM_CELLS]) begin
               if (k_ff == limit_ff) begin
                  // All iterations done without escape (also the zero limit).
                  count_in  = '0;
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end else if (fine_escape) begin
                  count_in  = limit_ff - k_ff;
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end else begin
                  nre_in   = new_re;
                  nim_in   = new_im;
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            k_in = k_next;
            if (coarse_escape) begin
               count_in  = limit_ff - k_next;
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end else begin
               z_re_in  = nre_ff[OP_BITS-1:0];
               z_im_in  = nim_ff[OP_BITS-1:0];
               state_in = ST_LAUNCH;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Wait here only while the previous result still sits unclaimed.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               rsp_gray_in  = (count_ff == '0) ? '0 : div_quotient;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      z_re_ff      <= z_re_in;
      z_im_ff      <= z_im_in;
      c_re_ff      <= c_re_in;
      c_im_ff      <= c_im_in;
      k_ff         <= k_in;
      nre_ff       <= nre_in;
      nim_ff       <= nim_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
      rsp_gray_ff  <= rsp_gray_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_BITS'(0), rsp_gray_ff, rsp_count_ff};

endmodule

// ----- verif/tb_escape_time_fractal_pixel_top.sv -----
// Testbench for escape_time_fractal_pixel_top: streams plane points in, checks every
// remaining count and gray level against a bit-exact Mandelbrot/Julia predictor.
// Depends on etf_pkg (register indexes, port widths) and the design top level.
module tb_escape_time_fractal_pixel_top;
   timeunit 1ns;
   timeprecision 1ps;

   import etf_pkg::*;

   // Plane values are Q4.28. These are kept apart from the package on purpose,
   // so that a wrong constant in the design cannot hide in the prediction.
   localparam int FRAC = 28;
   localparam logic signed [31:0] ONE_Q = 32'sd268435456;    // 1.0
   localparam logic signed [31:0] TWO_Q = 32'sd536870912;    // 2.0
   localparam logic signed [31:0] MAX_Q = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MIN_Q = 32'sh8000_0000;
   // Half-width of the square that holds the interesting part of both sets.
   localparam int unsigned NEAR_SPAN = 32'd603979776;         // 2.25

   // |z|^2 > 4 in the squared scale of the products.
   localparam logic [128:0] ESCAPE_RADIUS_SQ = 129'd1 << (2 * FRAC + 2);

   localparam logic MODE_MANDELBROT = 1'b0;
   localparam logic MODE_JULIA      = 1'b1;

   localparam logic [9:0]  RESET_LIMIT = 10'd100;
   localparam logic signed [31:0] RESET_C_RE = 32'sd107374182;
   localparam logic signed [31:0] RESET_C_IM = 32'sd80530637;

   // Cycles to let pass once the last result is in, before a register write
   // and at the end of the run.
   localparam int SETTLE_CYCLES = 20;
   localparam int DRAIN_CYCLES  = 50;
   // Bound on the whole run, several times the slowest correct run.
   localparam int CYCLE_LIMIT   = 3_000_000;

   typedef struct packed {
      logic [7:0] gray_level;
      logic [9:0] remaining_count;
   } pixel_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [31:0] csr_data   = '0;

   // Shadow copy of the block's registers, updated at each accepted write.
   logic               cfg_mode;
   logic signed [31:0] cfg_c_re;
   logic signed [31:0] cfg_c_im;
   logic [9:0]         cfg_limit;

   // Results still owed by the block, oldest first.
   pixel_result_type pending_pixels[$];

   int  mismatches   = 0;
   int  cycle_count  = 0;
   int  stall_left   = 0;
   bit  idle_enabled = 1'b1;

   escape_time_fractal_pixel_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // point_re[31:0], point_im[63:32]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // remaining_count[9:0], gray_level[17:10], zeros above
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Escape-time count for one point under the current shadow registers.
   // z is carried in 64 bits; products are exact in 128 bits and the shifts
   // floor toward minus infinity, the same as the block's datapath.
   function automatic pixel_result_type predict_pixel(input logic signed [31:0] pt_re,
                                                      input logic signed [31:0] pt_im);
      logic signed [63:0]  z_re;
      logic signed [63:0]  z_im;
      logic signed [63:0]  c_re;
      logic signed [63:0]  c_im;
      logic signed [127:0] sq_re;
      logic signed [127:0] sq_im;
      logic signed [127:0] cross_prod;
      logic [128:0]        mag_sq;
      logic [9:0]          count;
      int                  iter;
      bit                  escaped;
      pixel_result_type    res;
      if (cfg_mode == MODE_JULIA) begin
         z_re = pt_re;
         z_im = pt_im;
         c_re = cfg_c_re;
         c_im = cfg_c_im;
      end else begin
         z_re = '0;
         z_im = '0;
         c_re = pt_re;
         c_im = pt_im;
      end
      count   = '0;
      iter    = 0;
      escaped = 1'b0;
      while (!escaped && iter < cfg_limit) begin
         iter++;
         sq_re = z_re * z_re;
         sq_im = z_im * z_im;
         cross_prod = z_re * z_im;
         sq_re = sq_re >>> FRAC;
         sq_im = sq_im >>> FRAC;
         cross_prod = cross_prod >>> (FRAC - 1);
         z_re  = sq_re[63:0] - sq_im[63:0] + c_re;
         z_im  = cross_prod[63:0] + c_im;
         sq_re  = z_re * z_re;
         sq_im  = z_im * z_im;
         mag_sq = {1'b0, sq_re} + {1'b0, sq_im};
         if (mag_sq > ESCAPE_RADIUS_SQ) begin
            escaped = 1'b1;
            count   = 10'(cfg_limit - iter);
         end
      end
      res.remaining_count = count;
      res.gray_level = (cfg_limit == 0) ? 8'd0
                       : 8'((255 * int'(count)) / int'(cfg_limit));
      return res;
   endfunction

   // Uniform value in [-span, span], in Q4.28.
   function automatic logic signed [31:0] rand_around(input int unsigned span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   function automatic logic signed [31:0] rand_extreme();
      case ($urandom_range(0, 6))
         0:       return 32'sd0;
         1:       return 32'sd1;
         2:       return -32'sd1;
         3:       return MAX_Q;
         4:       return MIN_Q;
         5:       return TWO_Q;
         default: return -TWO_Q;
      endcase
   endfunction

   // Register write on the configuration channel. The valid stays up between
   // back-to-back writes and is dropped only after the last one of a group.
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [31:0] data, input bit last);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_FRACTAL_MODE:    cfg_mode  = data[0];
         CSR_JULIA_CONST_RE:  cfg_c_re  = data;
         CSR_JULIA_CONST_IM:  cfg_c_im  = data;
         CSR_ITERATION_LIMIT: cfg_limit = data[9:0];
         default: ;    // unused index, the block ignores it
      endcase
      if (last)
         csr_valid <= 1'b0;
   endtask

   // Full register set. Bits above the mode and limit fields carry noise,
   // which the block has to drop.
   task automatic configure(input logic mode, input logic signed [31:0] c_re,
                            input logic signed [31:0] c_im, input logic [9:0] limit);
      logic [31:0] word;
      word = $urandom;
      word[0] = mode;
      write_csr(CSR_FRACTAL_MODE, word, 1'b0);
      write_csr(CSR_JULIA_CONST_RE, c_re, 1'b0);
      write_csr(CSR_JULIA_CONST_IM, c_im, 1'b0);
      word = $urandom;
      word[9:0] = limit;
      write_csr(CSR_ITERATION_LIMIT, word, 1'b1);
   endtask

   // One point beat, with an optional idle burst in front of it. The expected
   // result is worked out at the edge where the beat is taken.
   task automatic send_point(input logic signed [31:0] pt_re, input logic signed [31:0] pt_im);
      if (idle_enabled && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pt_im, pt_re};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_pixels.insert(pending_pixels.size(), predict_pixel(pt_re, pt_im));
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // The block is idle once every result is in; the extra cycles cover the
   // output register and the handshake back to the input.
   task automatic wait_idle();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      // Mandelbrot at limit 100 straight out of reset.
      send_point(32'sd0, 32'sd0);           // the origin never escapes
      send_point(-TWO_Q, 32'sd0);           // sits on |z| = 2 forever, never above it
      send_point(TWO_Q, 32'sd0);            // equal to the bound first, above it next
      send_point(MAX_Q, MAX_Q);
      send_point(MIN_Q, MIN_Q);
      send_point(MIN_Q, MAX_Q);
      send_point(32'sd1, -32'sd1);
      send_point(-32'sd201326592, 32'sd26843546);   // near the neck, slow escape
      send_point(32'sd67108864, 32'sd0);            // the cusp at 0.25
      // Julia with the constants the block comes up with.
      drain_results();
      write_csr(CSR_FRACTAL_MODE, {31'd0, MODE_JULIA}, 1'b1);
      send_point(32'sd0, 32'sd0);
      send_point(MAX_Q, MIN_Q);
      send_point(-(ONE_Q >>> 1), ONE_Q >>> 1);
   endtask

   task automatic test_limit_extremes();
      // A point that escapes on the last allowed iteration counts as zero.
      wait_idle();
      configure(MODE_MANDELBROT, RESET_C_RE, RESET_C_IM, 10'd1);
      send_point(3 * ONE_Q, 32'sd0);
      send_point(32'sd0, 32'sd0);
      wait_idle();
      write_csr(CSR_ITERATION_LIMIT, 32'd2, 1'b1);
      send_point(TWO_Q, 32'sd0);
      // With a zero limit nothing is iterated and both fields are zero.
      wait_idle();
      write_csr(CSR_ITERATION_LIMIT, 32'd0, 1'b1);
      send_point(TWO_Q, 32'sd0);
      send_point(MAX_Q, MAX_Q);
      wait_idle();
      write_csr(CSR_FRACTAL_MODE, {31'd0, MODE_JULIA}, 1'b1);
      send_point(32'sd0, 32'sd0);
      // Largest limit: a few points only, since each may run the full loop.
      wait_idle();
      configure(MODE_MANDELBROT, RESET_C_RE, RESET_C_IM, 10'd1023);
      send_point(32'sd0, 32'sd0);
      send_point(-32'sd201326592, 32'sd2684355);
      send_point(TWO_Q, 32'sd0);
      // c = -1 settles into the cycle 0, -1 and stays bounded.
      wait_idle();
      configure(MODE_JULIA, -ONE_Q, 32'sd0, 10'd1023);
      send_point(32'sd0, 32'sd0);
   endtask

   task automatic test_register_masking();
      logic [31:0] word;
      wait_idle();
      configure(MODE_MANDELBROT, RESET_C_RE, RESET_C_IM, RESET_LIMIT);
      word = $urandom;
      word[9:0] = 10'd5;
      write_csr(CSR_ITERATION_LIMIT, word, 1'b0);
      // Writes to indexes past the last register must leave everything alone.
      repeat (3)
         write_csr(CSR_INDEX_BITS'($urandom_range(CSR_ITERATION_LIMIT + 1,
                                                  (1 << CSR_INDEX_BITS) - 1)),
                   $urandom, 1'b0);
      word = $urandom;
      word[0] = MODE_JULIA;
      write_csr(CSR_FRACTAL_MODE, word, 1'b1);
      send_point(32'sd0, 32'sd0);
      send_point(rand_around(NEAR_SPAN), rand_around(NEAR_SPAN));
      send_point(TWO_Q, -TWO_Q);
   endtask

   // One random setting of the registers, then a stream of points. Most points
   // lie where the count is interesting; the rest are full-range and extremes.
   task automatic run_random_phase(input logic [9:0] limit, input int n_items,
                                   input bit with_idle);
      logic               mode;
      logic signed [31:0] c_re;
      logic signed [31:0] c_im;
      logic signed [31:0] p_re;
      logic signed [31:0] p_im;
      wait_idle();
      idle_enabled = with_idle;
      mode = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 4) == 0) begin
         c_re = $urandom;
         c_im = $urandom;
      end else begin
         c_re = rand_around(ONE_Q);
         c_im = rand_around(ONE_Q);
      end
      configure(mode, c_re, c_im, limit);
      for (int i = 0; i < n_items; i++) begin
         case ($urandom_range(0, 9))
            0: begin
               p_re = $urandom;
               p_im = $urandom;
            end
            1: begin
               p_re = rand_extreme();
               p_im = rand_extreme();
            end
            default: begin
               p_re = rand_around(NEAR_SPAN);
               p_im = rand_around(NEAR_SPAN);
            end
         endcase
         send_point(p_re, p_im);
         // Now and then hold the input until the block has emptied.
         if ($urandom_range(0, 99) == 0)
            drain_results();
      end
   endtask

   task automatic test_random_phases();
      logic [9:0] limits [8];
      limits = '{10'd1, 10'd2, 10'd9, 10'd30, 10'd100, 10'd1023, 10'd64, 10'd17};
      for (int p = 0; p < 8; p++)
         run_random_phase(limits[p], (limits[p] > 10'd256) ? 25 : 200,
                          $urandom_range(0, 3) != 0);
   endtask

   task automatic test_final_stretch();
      // Both sides run flat out here.
      run_random_phase(10'($urandom_range(1, 50)), 120, 1'b0);
   endtask

   // Result side: random stall bursts on rsp_tready and a field-by-field
   // compare of every accepted beat against the oldest expectation.
   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_pixels.size() == 0) begin
               $error("result beat with no point outstanding: remaining_count %0d, gray_level %0d",
                      rsp_tdata[9:0], rsp_tdata[17:10]);
               mismatches++;
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_tdata[9:0] !== want.remaining_count) begin
                  $error("remaining_count: expected %0d, actual %0d",
                         want.remaining_count, rsp_tdata[9:0]);
                  mismatches++;
               end
               if (rsp_tdata[17:10] !== want.gray_level) begin
                  $error("gray_level: expected %0d, actual %0d",
                         want.gray_level, rsp_tdata[17:10]);
                  mismatches++;
               end
            end
         end
         if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(0, 4);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      cfg_mode  = MODE_MANDELBROT;
      cfg_c_re  = RESET_C_RE;
      cfg_c_im  = RESET_C_IM;
      cfg_limit = RESET_LIMIT;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_limit_extremes();
      test_register_masking();
      test_random_phases();
      test_final_stretch();

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
